[hw/rtl/sct_pkg.sv]
package sct_pkg;

   // Pi in unsigned Q.32, rounded.
   localparam logic [63:0] PI_Q32 = 64'd13493037705;
   localparam logic [33:0] PI_R = 34'd13493037705;
   localparam logic [33:0] HALF_PI_R = 34'd6746518852;

   // One in Q2.30 and the rounding constant for a Q2.30 product.
   localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
   localparam logic [63:0] ROUND_Q30 = 64'd536870912;

   // Widths of the series datapath.
   localparam int TERM_W = 32;
   localparam int SUM_W = 34;

   // Command codes of a transaction.
   localparam logic CMD_SINE = 1'b0;
   localparam logic CMD_COSINE = 1'b1;

   // Control that travels with every transaction through the pipeline.
   typedef struct packed {
      logic valid;
      logic cmd;
      logic flip;
   } sct_item_type;

endpackage

[hw/rtl/sct_reduce_cell.sv]
module sct_reduce_cell
   import sct_pkg::*;
#(
   parameter int AW = 40,
   parameter int SHIFT = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  sct_item_type  item_i,
   input  logic [AW-1:0] rem_i,
   output sct_item_type  item_o,
   output logic [AW-1:0] rem_o
);

   localparam logic [AW-1:0] DIVISOR = AW'(PI_Q32 << SHIFT);

   sct_item_type  item_ff, item_in;
   logic [AW-1:0] rem_ff, rem_in;
   logic          qbit;

   // One restoring division step; only the lowest quotient bit affects the sign.
   always_comb begin
      qbit = (rem_i >= DIVISOR);
      rem_in = qbit ? (rem_i - DIVISOR) : rem_i;
      item_in = item_i;
      if (SHIFT == 0) begin
         item_in.flip = item_i.flip ^ qbit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff <= '0;
      end else begin
         item_ff <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
   end

   assign item_o = item_ff;
   assign rem_o = rem_ff;

endmodule

[hw/rtl/sct_series_cell.sv]
module sct_series_cell
   import sct_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int SINE_TERMS = 11,
   parameter int COSINE_TERMS = 9
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sct_item_type            item_i,
   input  logic [31:0]             x2_i,
   input  logic [TERM_W-1:0]       term_i,
   input  logic signed [SUM_W-1:0] sum_i,
   output sct_item_type            item_o,
   output logic [31:0]             x2_o,
   output logic [TERM_W-1:0]       term_o,
   output logic signed [SUM_W-1:0] sum_o
);

   // Divisors of this term for each function and their exact reciprocals
   // for dividends below 2^33.
   localparam int DS = (2 * INDEX + 2) * (2 * INDEX + 3);
   localparam int DC = (2 * INDEX + 3) * (2 * INDEX + 4);
   localparam int LS = $clog2(DS);
   localparam int LC = $clog2(DC);
   localparam logic [63:0] RS = ((64'd1 << (33 + LS)) / DS) + 64'd1;
   localparam logic [63:0] RC = ((64'd1 << (33 + LC)) / DC) + 64'd1;
   localparam logic [32:0] HS = 33'(DS / 2);
   localparam logic [32:0] HC = 33'(DC / 2);
   localparam logic ACT_S = (INDEX < SINE_TERMS);
   localparam logic ACT_C = (INDEX < COSINE_TERMS);
   localparam logic ODD = ((INDEX % 2) == 1);

   sct_item_type            item1_ff, item1_in, item2_ff, item3_ff;
   logic [31:0]             x2_1_ff, x2_2_ff, x2_3_ff;
   logic signed [SUM_W-1:0] sum1_ff, sum1_in, sum2_ff, sum3_ff;
   logic [63:0]             prod1_ff, prod1_in;
   logic [63:0]             rounded;
   logic [32:0]             tp;
   logic [34:0]             recip;
   logic [49:0]             phi_ff, phi_in;
   logic [50:0]             plo_ff, plo_in;
   logic [68:0]             total;
   logic [68:0]             shifted;
   logic [TERM_W-1:0]       term3_ff, term3_in;

   // Stage one: accumulate this term and multiply it by x squared.
   always_comb begin
      item1_in = item_i;
      sum1_in = sum_i;
      if (item_i.cmd ? ACT_C : ACT_S) begin
         if (item_i.cmd ^ ODD) begin
            sum1_in = sum_i - SUM_W'($signed({1'b0, term_i}));
         end else begin
            sum1_in = sum_i + SUM_W'($signed({1'b0, term_i}));
         end
      end
      prod1_in = 64'(term_i) * 64'(x2_i);
   end

   // Stage two: round the product, add half the divisor, and form the partial
   // products of the reciprocal multiplication.
   always_comb begin
      rounded = prod1_ff + ROUND_Q30;
      tp = rounded[62:30] + (item1_ff.cmd ? HC : HS);
      recip = item1_ff.cmd ? RC[34:0] : RS[34:0];
      phi_in = 50'(tp) * 50'(recip[34:18]);
      plo_in = 51'(tp) * 51'(recip[17:0]);
   end

   // Stage three: combine the partial products and shift out the quotient.
   always_comb begin
      total = {1'b0, phi_ff, 18'b0} + 69'(plo_ff);
      shifted = item2_ff.cmd ? (total >> (33 + LC)) : (total >> (33 + LS));
      term3_in = shifted[TERM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item1_ff <= '0;
         item2_ff <= '0;
         item3_ff <= '0;
      end else begin
         item1_ff <= item1_in;
         item2_ff <= item1_ff;
         item3_ff <= item2_ff;
      end
   end

   always_ff @(posedge clock) begin
      x2_1_ff <= x2_i;
      x2_2_ff <= x2_1_ff;
      x2_3_ff <= x2_2_ff;
      sum1_ff <= sum1_in;
      sum2_ff <= sum1_ff;
      sum3_ff <= sum2_ff;
      prod1_ff <= prod1_in;
      phi_ff <= phi_in;
      plo_ff <= plo_in;
      term3_ff <= term3_in;
   end

   assign item_o = item3_ff;
   assign x2_o = x2_3_ff;
   assign term_o = term3_ff;
   assign sum_o = sum3_ff;

endmodule

[hw/rtl/sine_cosine_taylor_top.sv]
// Sine and cosine unit with range reduction and a Taylor series.
// A transaction is taken at a rising clock edge where start is high and busy
// is low. req_command selects sine (0) or cosine (1); req_angle is a signed
// Q8.24 angle in radians. The result is a signed Q2.30 value in rsp_value,
// saturated to the range minus one to one, shown for one cycle with
// rsp_valid high.
// The pipeline holds an input register, one division cell per quotient bit of
// the angle divided by pi, the fold, square and series setup registers, three
// stages per series term cell and an output register.
// A new transaction can be taken in every cycle in which busy is low, so the
// throughput is one result per clock, delivered in acceptance order.
// busy is high only during reset. Reset clears all valid flags, so any
// transaction in flight is dropped.
// The receiver cannot stall; results leave the pipeline as they finish.
module sine_cosine_taylor_top
   import sct_pkg::*;
#(
   parameter int SINE_TERMS = 11,
   parameter int COSINE_TERMS = 9,
   parameter int ANGLE_FRACTION_BITS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_command,
   input  logic signed [31:0] req_angle,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_value
);

   localparam int AW = 64 - ANGLE_FRACTION_BITS;
   localparam int NW = AW - 33;
   localparam int NC = (SINE_TERMS > COSINE_TERMS) ? SINE_TERMS : COSINE_TERMS;

   sct_item_type            in_item_ff, in_item_in;
   logic [AW-1:0]           in_a_ff, in_a_in;
   logic [31:0]             mag;

   sct_item_type            div_item [0:NW];
   logic [AW-1:0]           div_rem [0:NW];

   sct_item_type            fold_item_ff, fold_item_in;
   logic [31:0]             fold_x_ff, fold_x_in;
   logic [33:0]             fold_r;
   logic [34:0]             fold_rr;

   sct_item_type            sq_item_ff;
   logic [31:0]             sq_x_ff;
   logic [63:0]             sq_prod_ff;

   sct_item_type            init_item_ff;
   logic [31:0]             init_x2_ff, init_x2_in;
   logic [TERM_W-1:0]       init_term_ff, init_term_in;
   logic signed [SUM_W-1:0] init_sum_ff, init_sum_in;
   logic [63:0]             sq_round;
   logic [32:0]             x2_half;

   sct_item_type            ser_item [0:NC];
   logic [31:0]             ser_x2 [0:NC];
   logic [TERM_W-1:0]       ser_term [0:NC];
   logic signed [SUM_W-1:0] ser_sum [0:NC];

   logic                    out_valid_ff;
   logic signed [31:0]      out_value_ff, out_value_in;
   logic signed [SUM_W:0]   signed_sum;

   assign busy = reset;

   // Input stage: magnitude of the angle in Q.32 and the sign of an odd sine.
   always_comb begin
      mag = req_angle[31] ? 32'(-req_angle) : req_angle;
      in_a_in = AW'(mag) << (32 - ANGLE_FRACTION_BITS);
      in_item_in.valid = start & ~busy;
      in_item_in.cmd = req_command;
      in_item_in.flip = req_angle[31] & ~req_command;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_item_ff <= '0;
      end else begin
         in_item_ff <= in_item_in;
      end
   end

   always_ff @(posedge clock) begin
      in_a_ff <= in_a_in;
   end

   assign div_item[0] = in_item_ff;
   assign div_rem[0] = in_a_ff;

   // Angle modulo pi, one quotient bit per cell.
   for (genvar j = 0; j < NW; j++) begin : g_div
      sct_reduce_cell #(
         .AW    (AW),
         .SHIFT (NW - 1 - j)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .item_i (div_item[j]),
         .rem_i  (div_rem[j]),
         .item_o (div_item[j+1]),
         .rem_o  (div_rem[j+1])
      );
   end

   // Reflect about pi/2 and convert to Q2.30.
   always_comb begin
      fold_item_in = div_item[NW];
      fold_r = div_rem[NW][33:0];
      if (fold_r > HALF_PI_R) begin
         fold_r = PI_R - fold_r;
         fold_item_in.flip = div_item[NW].flip ^ div_item[NW].cmd;
      end
      fold_rr = 35'(fold_r) + 35'd2;
      fold_x_in = fold_rr[33:2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_item_ff <= '0;
         sq_item_ff <= '0;
         init_item_ff <= '0;
      end else begin
         fold_item_ff <= fold_item_in;
         sq_item_ff <= fold_item_ff;
         init_item_ff <= sq_item_ff;
      end
   end

   // Square of x, then the rounded Q2.30 square and the first series term.
   always_comb begin
      sq_round = sq_prod_ff + ROUND_Q30;
      init_x2_in = sq_round[61:30];
      x2_half = 33'(init_x2_in) + 33'd1;
      init_term_in = sq_item_ff.cmd ? TERM_W'(x2_half[32:1]) : TERM_W'(sq_x_ff);
      init_sum_in = sq_item_ff.cmd ? ONE_Q30 : '0;
   end

   always_ff @(posedge clock) begin
      fold_x_ff <= fold_x_in;
      sq_x_ff <= fold_x_ff;
      sq_prod_ff <= 64'(fold_x_ff) * 64'(fold_x_ff);
      init_x2_ff <= init_x2_in;
      init_term_ff <= init_term_in;
      init_sum_ff <= init_sum_in;
   end

   assign ser_item[0] = init_item_ff;
   assign ser_x2[0] = init_x2_ff;
   assign ser_term[0] = init_term_ff;
   assign ser_sum[0] = init_sum_ff;

   // Series terms, one cell per term.
   for (genvar i = 0; i < NC; i++) begin : g_ser
      sct_series_cell #(
         .INDEX        (i),
         .SINE_TERMS   (SINE_TERMS),
         .COSINE_TERMS (COSINE_TERMS)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .item_i (ser_item[i]),
         .x2_i   (ser_x2[i]),
         .term_i (ser_term[i]),
         .sum_i  (ser_sum[i]),
         .item_o (ser_item[i+1]),
         .x2_o   (ser_x2[i+1]),
         .term_o (ser_term[i+1]),
         .sum_o  (ser_sum[i+1])
      );
   end

   // Apply the collected sign and saturate to minus one to one.
   always_comb begin
      signed_sum = ser_item[NC].flip ? -(SUM_W + 1)'(ser_sum[NC])
                                     : (SUM_W + 1)'(ser_sum[NC]);
      if (signed_sum > (SUM_W + 1)'(ONE_Q30)) begin
         out_value_in = 32'(ONE_Q30);
      end else if (signed_sum < -(SUM_W + 1)'(ONE_Q30)) begin
         out_value_in = -32'(ONE_Q30);
      end else begin
         out_value_in = signed_sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= ser_item[NC].valid;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff <= out_value_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_value = out_value_ff;

endmodule

[hw/rtl/sct_checker.sv]
module sct_checker
   import sct_pkg::*;
#(
   parameter int SINE_TERMS = 11,
   parameter int COSINE_TERMS = 9,
   parameter int ANGLE_FRACTION_BITS = 24
) (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               req_command,
   input logic signed [31:0] req_angle,
   input logic               rsp_valid,
   input logic signed [31:0] rsp_value
);

   localparam int NC = (SINE_TERMS > COSINE_TERMS) ? SINE_TERMS : COSINE_TERMS;
   localparam int LAT = (31 - ANGLE_FRACTION_BITS) + 5 + 3 * NC;

   // Every accepted transaction yields a result after the fixed latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("missing result after accepted transaction");

   // No result appears without a transaction accepted at the matching time.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without a matching transaction");

   // Results stay within minus one to one.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_value <= 32'sd1073741824 && rsp_value >= -32'sd1073741824))
      else $error("result outside saturation range");

   // The cosine of zero is exactly one.
   a_cos_zero: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command && req_angle == 32'sd0)
      |-> ##LAT (rsp_value == 32'sd1073741824))
      else $error("cosine of zero is not one");

endmodule

bind sine_cosine_taylor_top sct_checker #(
   .SINE_TERMS          (SINE_TERMS),
   .COSINE_TERMS        (COSINE_TERMS),
   .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
) u_sct_checker (.*);
